>>> rtl/core/mcc_pkg.sv
package mcc_pkg;

    // Width of one subblock cost.
    localparam int COST_WIDTH = 20;

    // Sums grow by one bit for every doubling of the number of terms.
    localparam int PAIR_W  = COST_WIDTH + 1;
    localparam int QUAD_W  = COST_WIDTH + 2;
    localparam int TOTAL_W = COST_WIDTH + 3;

    // Configuration fields.
    localparam int DEPTH_W   = 5;
    localparam int BASE_W    = 16;
    localparam int SHIFT_W   = 4;
    localparam int SHIFT_MAX = 8;
    localparam int DEPTH_MIN = 8;
    localparam int DEPTH_MAX = 16;
    localparam int THR_W     = BASE_W + SHIFT_MAX;

    // Common width for every comparison against a threshold.
    localparam int CMP_W = (TOTAL_W > THR_W) ? TOTAL_W : THR_W;

    localparam int LEVEL_W = 2;
    localparam int NUM_COSTS = 8;

    // APB register map: one 32-bit word per register.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int INDEX_W = 3;

    typedef enum logic [INDEX_W-1:0] {
        REG_BIT_DEPTH     = 3'd0,
        REG_ULTRA_FLAT    = 3'd1,
        REG_FLAT          = 3'd2,
        REG_COMPLEX       = 3'd3,
        REG_ULTRA_COMPLEX = 3'd4
    } reg_index_t;

    typedef logic [NUM_COSTS-1:0][COST_WIDTH-1:0] cost_vec_t;

    // Thresholds already scaled to the sample bit depth.
    typedef struct packed {
        logic [CMP_W-1:0] ultra_flat;
        logic [CMP_W-1:0] flat;
        logic [CMP_W-1:0] complex;
        logic [CMP_W-1:0] ultra_complex;
    } thr_t;

    // Whole sum and the extremes of the quad and pair sums.
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [QUAD_W-1:0]  quad_min;
        logic [QUAD_W-1:0]  quad_max;
        logic [PAIR_W-1:0]  pair_min;
        logic [PAIR_W-1:0]  pair_max;
    } ext_t;

endpackage

>>> rtl/core/mixed_complexity_classifier_unit.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------
// cost     | cost_valid/stall     | block_cost_0 .. block_cost_7 (20 b)
// mix      | mix_valid/stall      | mix_level (2 b)
// config   | APB psel/penable     | paddr (5 b), pwdata/prdata (32 b)
//
// A transaction on the cost channel yields exactly one mix transaction, which
// passes the three registers in order; one transaction is taken every cycle
// while cost_stall is low. The rate is set by the three pipeline registers
// (input, sums and extremes, result), each of which may refill while the next drains.
// rst_n clears the stage valid flags and the configuration registers
// asynchronously. A stall on the mix channel holds the result and backs up
// stage by stage; cost_stall rises only when all three stages are full.
module mixed_complexity_classifier_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cost_valid,
    output logic                            cost_stall,
    input  logic [mcc_pkg::COST_WIDTH-1:0]  block_cost_0,
    input  logic [mcc_pkg::COST_WIDTH-1:0]  block_cost_1,
    input  logic [mcc_pkg::COST_WIDTH-1:0]  block_cost_2,
    input  logic [mcc_pkg::COST_WIDTH-1:0]  block_cost_3,
    input  logic [mcc_pkg::COST_WIDTH-1:0]  block_cost_4,
    input  logic [mcc_pkg::COST_WIDTH-1:0]  block_cost_5,
    input  logic [mcc_pkg::COST_WIDTH-1:0]  block_cost_6,
    input  logic [mcc_pkg::COST_WIDTH-1:0]  block_cost_7,
    output logic                            mix_valid,
    input  logic                            mix_stall,
    output logic [mcc_pkg::LEVEL_W-1:0]     mix_level,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mcc_pkg::ADDR_W-1:0]      paddr,
    input  logic [mcc_pkg::DATA_W-1:0]      pwdata,
    output logic [mcc_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import mcc_pkg::*;

    thr_t               thr;
    ext_t               ext;
    logic [LEVEL_W-1:0] level;

    // Stage valid flags and their next values.
    logic in_valid_reg,  in_valid_next;
    logic ext_valid_reg, ext_valid_next;
    logic res_valid_reg, res_valid_next;

    // A stage may load when it is empty or its contents move on this cycle.
    logic in_ready, ext_ready, res_ready;

    cost_vec_t          cost_reg;
    ext_t               ext_reg;
    logic [LEVEL_W-1:0] level_reg;

    mcc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thr     (thr)
    );

    mcc_extremes u_ext (
        .cost (cost_reg),
        .ext  (ext)
    );

    mcc_classify u_cls (
        .ext   (ext_reg),
        .thr   (thr),
        .level (level)
    );

    assign res_ready = !res_valid_reg || !mix_stall;
    assign ext_ready = !ext_valid_reg || res_ready;
    assign in_ready  = !in_valid_reg || ext_ready;

    assign in_valid_next  = in_ready  ? cost_valid    : in_valid_reg;
    assign ext_valid_next = ext_ready ? in_valid_reg  : ext_valid_reg;
    assign res_valid_next = res_ready ? ext_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            ext_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            ext_valid_reg <= ext_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers load only alongside a valid transaction.
    always_ff @(posedge clk)
    begin
        if (in_ready && cost_valid)
        begin
            cost_reg[0] <= block_cost_0;
            cost_reg[1] <= block_cost_1;
            cost_reg[2] <= block_cost_2;
            cost_reg[3] <= block_cost_3;
            cost_reg[4] <= block_cost_4;
            cost_reg[5] <= block_cost_5;
            cost_reg[6] <= block_cost_6;
            cost_reg[7] <= block_cost_7;
        end
        if (ext_ready && in_valid_reg)
            ext_reg <= ext;
        if (res_ready && ext_valid_reg)
            level_reg <= level;
    end

    assign cost_stall = !in_ready;
    assign mix_valid  = res_valid_reg;
    assign mix_level  = level_reg;

    // Every quad sum contains one of the pair sums, and no quad exceeds the total.
    a_extreme_order: assert property (@(posedge clk) disable iff (!rst_n)
        ext_valid_reg |-> (QUAD_W'(ext_reg.pair_min) <= ext_reg.quad_min)
                       && (ext_reg.quad_min <= ext_reg.quad_max)
                       && (ext_reg.pair_min <= ext_reg.pair_max))
        else $error("quad and pair extremes out of order");

    a_quad_in_total: assert property (@(posedge clk) disable iff (!rst_n)
        ext_valid_reg |-> (TOTAL_W'(ext_reg.quad_max) <= ext_reg.total))
        else $error("quad maximum exceeds the whole sum");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cost_valid && !cost_stall |=> in_valid_reg)
        else $error("accepted transaction lost at the input stage");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        cost_stall |-> in_valid_reg && ext_valid_reg && res_valid_reg && mix_stall)
        else $error("input stalled while the pipeline has room");

endmodule

>>> rtl/core/mcc_cfg_regs.sv
module mcc_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [mcc_pkg::DATA_W-1:0]  pwdata,
    output logic [mcc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output mcc_pkg::thr_t               thr
);
    import mcc_pkg::*;

    logic [DEPTH_W-1:0] depth_reg;
    logic [BASE_W-1:0]  vf_reg;
    logic [BASE_W-1:0]  f_reg;
    logic [BASE_W-1:0]  c_reg;
    logic [BASE_W-1:0]  vc_reg;
    logic               wr_en;
    logic [INDEX_W-1:0] index;
    logic [SHIFT_W-1:0] shift;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_W'(DEPTH_MIN);
            vf_reg    <= '0;
            f_reg     <= '0;
            c_reg     <= '0;
            vc_reg    <= '0;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_BIT_DEPTH:     depth_reg <= pwdata[DEPTH_W-1:0];
                REG_ULTRA_FLAT:    vf_reg    <= pwdata[BASE_W-1:0];
                REG_FLAT:          f_reg     <= pwdata[BASE_W-1:0];
                REG_COMPLEX:       c_reg     <= pwdata[BASE_W-1:0];
                REG_ULTRA_COMPLEX: vc_reg    <= pwdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_BIT_DEPTH:     prdata = DATA_W'(depth_reg);
            REG_ULTRA_FLAT:    prdata = DATA_W'(vf_reg);
            REG_FLAT:          prdata = DATA_W'(f_reg);
            REG_COMPLEX:       prdata = DATA_W'(c_reg);
            REG_ULTRA_COMPLEX: prdata = DATA_W'(vc_reg);
            default:           prdata = '0;
        endcase
    end

    // Bit depths outside 8 to 16 are clamped to the nearest end.
    always_comb
    begin
        if (depth_reg < DEPTH_W'(DEPTH_MIN))
            shift = '0;
        else if (depth_reg > DEPTH_W'(DEPTH_MAX))
            shift = SHIFT_W'(SHIFT_MAX);
        else
            shift = SHIFT_W'(depth_reg - DEPTH_W'(DEPTH_MIN));
    end

    assign thr.ultra_flat    = CMP_W'(vf_reg) << shift;
    assign thr.flat          = CMP_W'(f_reg) << shift;
    assign thr.complex       = CMP_W'(c_reg) << shift;
    assign thr.ultra_complex = CMP_W'(vc_reg) << shift;

endmodule

>>> rtl/core/mcc_extremes.sv
module mcc_extremes (
    input  mcc_pkg::cost_vec_t cost,
    output mcc_pkg::ext_t      ext
);
    import mcc_pkg::*;

    logic [PAIR_W-1:0]  pair [10];
    logic [QUAD_W-1:0]  quad [6];
    logic [PAIR_W-1:0]  pmin_l1 [5];
    logic [PAIR_W-1:0]  pmax_l1 [5];
    logic [QUAD_W-1:0]  qmin_l1 [3];
    logic [QUAD_W-1:0]  qmax_l1 [3];
    logic [PAIR_W-1:0]  pmin_a, pmin_b, pmax_a, pmax_b;
    logic [QUAD_W-1:0]  qmin_a, qmax_a;

    function automatic logic [PAIR_W-1:0] pmin2(logic [PAIR_W-1:0] a, logic [PAIR_W-1:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic [PAIR_W-1:0] pmax2(logic [PAIR_W-1:0] a, logic [PAIR_W-1:0] b);
        return (b > a) ? b : a;
    endfunction

    function automatic logic [QUAD_W-1:0] qmin2(logic [QUAD_W-1:0] a, logic [QUAD_W-1:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic [QUAD_W-1:0] qmax2(logic [QUAD_W-1:0] a, logic [QUAD_W-1:0] b);
        return (b > a) ? b : a;
    endfunction

    // Row neighbours, then columns.
    assign pair[0] = PAIR_W'(cost[0]) + PAIR_W'(cost[1]);
    assign pair[1] = PAIR_W'(cost[1]) + PAIR_W'(cost[2]);
    assign pair[2] = PAIR_W'(cost[2]) + PAIR_W'(cost[3]);
    assign pair[3] = PAIR_W'(cost[4]) + PAIR_W'(cost[5]);
    assign pair[4] = PAIR_W'(cost[5]) + PAIR_W'(cost[6]);
    assign pair[5] = PAIR_W'(cost[6]) + PAIR_W'(cost[7]);
    assign pair[6] = PAIR_W'(cost[0]) + PAIR_W'(cost[4]);
    assign pair[7] = PAIR_W'(cost[1]) + PAIR_W'(cost[5]);
    assign pair[8] = PAIR_W'(cost[2]) + PAIR_W'(cost[6]);
    assign pair[9] = PAIR_W'(cost[3]) + PAIR_W'(cost[7]);

    // Top, bottom, left, right, middle and edges, built from the pairs.
    assign quad[0] = QUAD_W'(pair[0]) + QUAD_W'(pair[2]);
    assign quad[1] = QUAD_W'(pair[3]) + QUAD_W'(pair[5]);
    assign quad[2] = QUAD_W'(pair[6]) + QUAD_W'(pair[7]);
    assign quad[3] = QUAD_W'(pair[8]) + QUAD_W'(pair[9]);
    assign quad[4] = QUAD_W'(pair[7]) + QUAD_W'(pair[8]);
    assign quad[5] = QUAD_W'(pair[6]) + QUAD_W'(pair[9]);

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            pmin_l1[i] = pmin2(pair[2*i], pair[2*i+1]);
            pmax_l1[i] = pmax2(pair[2*i], pair[2*i+1]);
        end
        for (int i = 0; i < 3; i++)
        begin
            qmin_l1[i] = qmin2(quad[2*i], quad[2*i+1]);
            qmax_l1[i] = qmax2(quad[2*i], quad[2*i+1]);
        end
    end

    assign pmin_a = pmin2(pmin_l1[0], pmin_l1[1]);
    assign pmin_b = pmin2(pmin_l1[2], pmin_l1[3]);
    assign pmax_a = pmax2(pmax_l1[0], pmax_l1[1]);
    assign pmax_b = pmax2(pmax_l1[2], pmax_l1[3]);
    assign qmin_a = qmin2(qmin_l1[0], qmin_l1[1]);
    assign qmax_a = qmax2(qmax_l1[0], qmax_l1[1]);

    assign ext.pair_min = pmin2(pmin2(pmin_a, pmin_b), pmin_l1[4]);
    assign ext.pair_max = pmax2(pmax2(pmax_a, pmax_b), pmax_l1[4]);
    assign ext.quad_min = qmin2(qmin_a, qmin_l1[2]);
    assign ext.quad_max = qmax2(qmax_a, qmax_l1[2]);
    assign ext.total    = TOTAL_W'(quad[0]) + TOTAL_W'(quad[1]);

endmodule

>>> rtl/core/mcc_classify.sv
module mcc_classify (
    input  mcc_pkg::ext_t                ext,
    input  mcc_pkg::thr_t                thr,
    output logic [mcc_pkg::LEVEL_W-1:0]  level
);
    import mcc_pkg::*;

    typedef enum logic [2:0] {
        CLS_ULTRA_FLAT    = 3'd0,
        CLS_FLAT          = 3'd1,
        CLS_MIDDLE        = 3'd2,
        CLS_COMPLEX       = 3'd3,
        CLS_ULTRA_COMPLEX = 3'd4
    } class_t;

    class_t cls_all, q_lo, q_hi, p_lo, p_hi;
    logic [2:0]         q_spread, p_spread;
    logic [LEVEL_W-1:0] lvl_q, lvl_p;

    // Tests run in a fixed order so that, with unordered thresholds, the flat
    // tests win over the complex ones and each extreme class over its neighbour.
    function automatic class_t classify(logic [CMP_W-1:0] x, thr_t t);
        class_t c;
        if (x < t.ultra_flat)
            c = CLS_ULTRA_FLAT;
        else if (x < t.flat)
            c = CLS_FLAT;
        else if (x > t.ultra_complex)
            c = CLS_ULTRA_COMPLEX;
        else if (x > t.complex)
            c = CLS_COMPLEX;
        else
            c = CLS_MIDDLE;
        return c;
    endfunction

    assign cls_all = classify(CMP_W'(ext.total), thr);
    assign q_lo    = classify(CMP_W'({ext.quad_min, 1'b0}), thr);
    assign q_hi    = classify(CMP_W'({ext.quad_max, 1'b0}), thr);
    assign p_lo    = classify(CMP_W'({ext.pair_min, 2'b00}), thr);
    assign p_hi    = classify(CMP_W'({ext.pair_max, 2'b00}), thr);

    assign q_spread = (q_hi >= q_lo) ? (q_hi - q_lo) : 3'd0;
    assign p_spread = (p_hi >= p_lo) ? (p_hi - p_lo) : 3'd0;

    always_comb
    begin
        case (q_spread)
            3'd4:    lvl_q = 2'd3;
            3'd3:    lvl_q = 2'd2;
            default: lvl_q = 2'd0;
        endcase
        case (p_spread)
            3'd4:    lvl_p = 2'd2;
            3'd3:    lvl_p = 2'd1;
            default: lvl_p = 2'd0;
        endcase
    end

    always_comb
    begin
        if (cls_all <= CLS_MIDDLE)
            level = '0;
        else
            level = (lvl_q > lvl_p) ? lvl_q : lvl_p;
    end

endmodule

>>> dv/mix_level_monitor.sv
module mix_level_monitor
    import mcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cost_valid,
    input  logic                cost_stall,
    input  cost_vec_t           costs,
    input  logic                mix_valid,
    input  logic                mix_stall,
    input  logic [LEVEL_W-1:0]  mix_level,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output int                  error_count,
    output int                  pending_count
);

    typedef enum logic [2:0] {
        CLS_ULTRA_FLAT    = 3'd0,
        CLS_FLAT          = 3'd1,
        CLS_MIDDLE        = 3'd2,
        CLS_COMPLEX       = 3'd3,
        CLS_ULTRA_COMPLEX = 3'd4
    } complexity_t;

    // Shadow copy of the configuration registers, following the APB writes.
    logic [DEPTH_W-1:0] bit_depth_cfg;
    logic [BASE_W-1:0]  ultra_flat_cfg;
    logic [BASE_W-1:0]  flat_cfg;
    logic [BASE_W-1:0]  complex_cfg;
    logic [BASE_W-1:0]  ultra_complex_cfg;

    logic [LEVEL_W-1:0] expected_levels[$];

    function automatic complexity_t complexity_of(logic [31:0] x, thr_t thr);
        if (x < thr.ultra_flat)
            return CLS_ULTRA_FLAT;
        if (x < thr.flat)
            return CLS_FLAT;
        if (x > thr.ultra_complex)
            return CLS_ULTRA_COMPLEX;
        if (x > thr.complex)
            return CLS_COMPLEX;
        return CLS_MIDDLE;
    endfunction

    function automatic logic [LEVEL_W-1:0] predict_mix_level(cost_vec_t cost);
        logic [31:0]        c[NUM_COSTS];
        logic [31:0]        pair_sum[10];
        logic [31:0]        quad_sum[6];
        logic [31:0]        total;
        logic [31:0]        pair_lo;
        logic [31:0]        pair_hi;
        logic [31:0]        quad_lo;
        logic [31:0]        quad_hi;
        logic [DEPTH_W-1:0] depth;
        int                 shift;
        thr_t               thr;
        complexity_t        q_lo_cls;
        complexity_t        q_hi_cls;
        complexity_t        p_lo_cls;
        complexity_t        p_hi_cls;
        int                 quad_spread;
        int                 pair_spread;
        logic [LEVEL_W-1:0] quad_level;
        logic [LEVEL_W-1:0] pair_level;

        total = '0;
        for (int i = 0; i < NUM_COSTS; i++)
        begin
            c[i] = 32'(cost[i]);
            total += c[i];
        end

        // Row neighbours first, then the four columns.
        pair_sum[0] = c[0] + c[1];
        pair_sum[1] = c[1] + c[2];
        pair_sum[2] = c[2] + c[3];
        pair_sum[3] = c[4] + c[5];
        pair_sum[4] = c[5] + c[6];
        pair_sum[5] = c[6] + c[7];
        pair_sum[6] = c[0] + c[4];
        pair_sum[7] = c[1] + c[5];
        pair_sum[8] = c[2] + c[6];
        pair_sum[9] = c[3] + c[7];

        // Top, bottom, left, right, middle and edges.
        quad_sum[0] = c[0] + c[1] + c[2] + c[3];
        quad_sum[1] = c[4] + c[5] + c[6] + c[7];
        quad_sum[2] = c[0] + c[1] + c[4] + c[5];
        quad_sum[3] = c[2] + c[3] + c[6] + c[7];
        quad_sum[4] = c[1] + c[2] + c[5] + c[6];
        quad_sum[5] = c[0] + c[3] + c[4] + c[7];

        pair_lo = pair_sum[0];
        pair_hi = pair_sum[0];
        for (int i = 1; i < 10; i++)
        begin
            if (pair_sum[i] < pair_lo)
                pair_lo = pair_sum[i];
            if (pair_sum[i] > pair_hi)
                pair_hi = pair_sum[i];
        end
        quad_lo = quad_sum[0];
        quad_hi = quad_sum[0];
        for (int i = 1; i < 6; i++)
        begin
            if (quad_sum[i] < quad_lo)
                quad_lo = quad_sum[i];
            if (quad_sum[i] > quad_hi)
                quad_hi = quad_sum[i];
        end

        // Bit depths outside the supported range are clamped to its ends.
        depth = bit_depth_cfg;
        if (depth < DEPTH_MIN)
            depth = DEPTH_W'(DEPTH_MIN);
        if (depth > DEPTH_MAX)
            depth = DEPTH_W'(DEPTH_MAX);
        shift = int'(depth) - DEPTH_MIN;
        thr.ultra_flat    = CMP_W'(ultra_flat_cfg) << shift;
        thr.flat          = CMP_W'(flat_cfg) << shift;
        thr.complex       = CMP_W'(complex_cfg) << shift;
        thr.ultra_complex = CMP_W'(ultra_complex_cfg) << shift;

        if (complexity_of(total, thr) <= CLS_MIDDLE)
            return '0;

        q_lo_cls = complexity_of(quad_lo << 1, thr);
        q_hi_cls = complexity_of(quad_hi << 1, thr);
        p_lo_cls = complexity_of(pair_lo << 2, thr);
        p_hi_cls = complexity_of(pair_hi << 2, thr);
        quad_spread = (q_hi_cls >= q_lo_cls) ? int'(q_hi_cls) - int'(q_lo_cls) : 0;
        pair_spread = (p_hi_cls >= p_lo_cls) ? int'(p_hi_cls) - int'(p_lo_cls) : 0;

        quad_level = (quad_spread == 4) ? 2'd3 : ((quad_spread == 3) ? 2'd2 : 2'd0);
        pair_level = (pair_spread == 4) ? 2'd2 : ((pair_spread == 3) ? 2'd1 : 2'd0);
        return (quad_level > pair_level) ? quad_level : pair_level;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [LEVEL_W-1:0] wanted;

        if (!rst_n)
        begin
            bit_depth_cfg     = DEPTH_W'(DEPTH_MIN);
            ultra_flat_cfg    = '0;
            flat_cfg          = '0;
            complex_cfg       = '0;
            ultra_complex_cfg = '0;
            expected_levels.delete();
            error_count       = 0;
            pending_count     = 0;
        end
        else
        begin
            if (cost_valid && !cost_stall)
                expected_levels.push_back(predict_mix_level(costs));

            if (mix_valid && !mix_stall)
            begin
                if (expected_levels.size() == 0)
                begin
                    $error("mix_level: no transaction expected, actual %0d", mix_level);
                    error_count++;
                end
                else
                begin
                    wanted = expected_levels.pop_front();
                    if (mix_level !== wanted)
                    begin
                        $error("mix_level mismatch: expected %0d, actual %0d",
                               wanted, mix_level);
                        error_count++;
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[ADDR_W-1:2]))
                    REG_BIT_DEPTH:     bit_depth_cfg     = pwdata[DEPTH_W-1:0];
                    REG_ULTRA_FLAT:    ultra_flat_cfg    = pwdata[BASE_W-1:0];
                    REG_FLAT:          flat_cfg          = pwdata[BASE_W-1:0];
                    REG_COMPLEX:       complex_cfg       = pwdata[BASE_W-1:0];
                    REG_ULTRA_COMPLEX: ultra_complex_cfg = pwdata[BASE_W-1:0];
                    default: ;
                endcase
            end

            pending_count = expected_levels.size();
        end
    end

endmodule

>>> dv/mixed_complexity_classifier_unit_test.sv
// Stimulus and verdict for the mixed complexity classifier. The monitor
// instantiated beside the block does all of the prediction and checking;
// this module only produces cost transactions, configuration writes and
// back-pressure, and then reports the outcome.
module mixed_complexity_classifier_unit_test;

    import mcc_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 10;
    localparam int IDLE_PERCENT    = 32;
    localparam int HOLD_OFF_CYCLES = 60;
    // The block has three pipeline stages, and this margin is ample for it to
    // settle once the last expected transaction has come out.
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int unsigned COST_MAX = (1 << COST_WIDTH) - 1;

    logic               clk;
    logic               rst_n;
    logic               cost_valid;
    logic               cost_stall;
    cost_vec_t          cost_word;
    logic               mix_valid;
    logic               mix_stall;
    logic [LEVEL_W-1:0] mix_level;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 level_errors;
    int                 levels_pending;
    int                 cycle_count = 0;

    // Both sides only idle while this is set; clearing it gives a stretch at
    // full rate.
    bit                 idle_enabled = 1'b1;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit                 hold_off_request = 1'b0;

    // Thresholds as the block will see them, used only to aim the random
    // costs at the interesting boundaries.
    int unsigned        aim_ultra_flat = 0;
    int unsigned        aim_flat = 0;
    int unsigned        aim_complex = 0;
    int unsigned        aim_ultra_complex = 0;

    mixed_complexity_classifier_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cost_valid   (cost_valid),
        .cost_stall   (cost_stall),
        .block_cost_0 (cost_word[0]),
        .block_cost_1 (cost_word[1]),
        .block_cost_2 (cost_word[2]),
        .block_cost_3 (cost_word[3]),
        .block_cost_4 (cost_word[4]),
        .block_cost_5 (cost_word[5]),
        .block_cost_6 (cost_word[6]),
        .block_cost_7 (cost_word[7]),
        .mix_valid    (mix_valid),
        .mix_stall    (mix_stall),
        .mix_level    (mix_level),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    mix_level_monitor level_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .cost_valid    (cost_valid),
        .cost_stall    (cost_stall),
        .costs         (cost_word),
        .mix_valid     (mix_valid),
        .mix_stall     (mix_stall),
        .mix_level     (mix_level),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .error_count   (level_errors),
        .pending_count (levels_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: a run that has not finished by now is hung.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver. It stalls at random while idling is allowed, and serves a
    // hold-off request by stalling for a long, fixed stretch so that the
    // pipeline fills and pushes back on the cost channel.
    initial
    begin
        mix_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                mix_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            mix_stall <= idle_enabled && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // One APB write: a setup phase, then an access phase held until pready.
    // psel then drops before the task returns so that a following write raises it afresh.
    task automatic write_register(reg_index_t index, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering transactions and wait until every expected mix level has
    // been delivered, then wait DRAIN_CYCLES for the pipeline to go quiet. The
    // pending count is sampled on the falling edge, away from the monitor.
    task automatic wait_for_drain();
        cost_valid <= 1'b0;
        do
            @(negedge clk);
        while (levels_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Reconfigure between phases, only once the block is idle.
    task automatic apply_config(int unsigned depth, int unsigned ultra_flat,
                                int unsigned flat, int unsigned complex,
                                int unsigned ultra_complex);
        int unsigned shift;

        wait_for_drain();
        write_register(REG_BIT_DEPTH, depth);
        write_register(REG_ULTRA_FLAT, ultra_flat);
        write_register(REG_FLAT, flat);
        write_register(REG_COMPLEX, complex);
        write_register(REG_ULTRA_COMPLEX, ultra_complex);

        shift = (depth < DEPTH_MIN) ? 0 :
                (depth > DEPTH_MAX) ? DEPTH_MAX - DEPTH_MIN : depth - DEPTH_MIN;
        aim_ultra_flat    = ultra_flat << shift;
        aim_flat          = flat << shift;
        aim_complex       = complex << shift;
        aim_ultra_complex = ultra_complex << shift;
    endtask

    // Offer one cost transaction, after a random number of idle cycles, and
    // hold it until the block accepts it.
    task automatic send_costs(cost_vec_t costs);
        while (idle_enabled && ($urandom_range(99) < IDLE_PERCENT))
        begin
            cost_valid <= 1'b0;
            @(posedge clk);
        end
        cost_valid <= 1'b1;
        cost_word  <= costs;
        do
            @(posedge clk);
        while (cost_stall);
    endtask

    // Cells selected by the mask take the high cost, the rest the low one.
    task automatic send_split(logic [7:0] high_cells, int unsigned high_cost,
                              int unsigned low_cost);
        cost_vec_t costs;

        for (int i = 0; i < NUM_COSTS; i++)
            costs[i] = COST_WIDTH'(high_cells[i] ? high_cost : low_cost);
        send_costs(costs);
    endtask

    // Mostly blocks that mix flat and complex subblocks in random places,
    // with costs placed around the scaled thresholds so that the pair and
    // quad extremes land in different classes. A small share is raw random
    // costs and all-or-nothing costs, which toggle every bit of every field.
    function automatic cost_vec_t random_costs();
        cost_vec_t   costs;
        int unsigned pick;
        logic [31:0] mask;
        int unsigned value;

        pick = $urandom_range(99);
        mask = $urandom;
        for (int i = 0; i < NUM_COSTS; i++)
        begin
            if (pick < 8)
                value = $urandom & COST_MAX;
            else if (pick < 12)
                value = mask[i] ? COST_MAX : 0;
            else if (mask[i])
                value = mask[i + 8] ?
                        $urandom_range(aim_ultra_complex / 4, aim_ultra_complex / 2 + 1) :
                        $urandom_range(aim_complex / 4, aim_ultra_complex / 4 + 1);
            else
                value = mask[i + 8] ?
                        $urandom_range(0, aim_ultra_flat / 8) :
                        $urandom_range(aim_flat / 8, aim_complex / 4);
            costs[i] = COST_WIDTH'((value > COST_MAX) ? COST_MAX : value);
        end
        return costs;
    endfunction

    task automatic send_random(int count);
        repeat (count) send_costs(random_costs());
    endtask

    initial
    begin
        int unsigned rnd_ultra_flat;
        int unsigned rnd_flat;
        int unsigned rnd_complex;
        int unsigned rnd_ultra_complex;

        rst_n      <= 1'b0;
        cost_valid <= 1'b0;
        cost_word  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: every threshold is zero, so only an all-zero
        // block is anything but very complex.
        send_random(60);

        // Directed transactions on a small, ordered set of thresholds
        // (64, 256, 1024, 4096 at 8 bits).
        apply_config(8, 64, 256, 1024, 4096);
        send_split(8'h00, 0, 0);
        send_split(8'hFF, COST_MAX, 0);
        send_split(8'hFF, 'h55555, 0);
        send_split(8'hFF, 'hAAAAA, 0);
        send_split(8'hF0, 1500, 0);         // complex bottom row, flat top row
        send_split(8'h0F, 1500, 0);         // complex top row
        send_split(8'h33, 1500, 0);         // complex left half
        send_split(8'h66, 1500, 0);         // complex middle columns
        send_split(8'h99, 1500, 0);         // complex outer columns
        send_split(8'h08, 3000, 0);         // one busy subblock in a flat block
        send_split(8'hA5, 1500, 2);         // checkerboard
        send_split(8'hFF, 128, 0);          // whole sum exactly on complex
        send_split(8'hFF, 129, 0);          // whole sum just above complex
        send_split(8'hFF, 8, 0);            // whole sum exactly on very flat
        send_split(8'hFF, 7, 0);            // whole sum just below very flat
        send_split(8'hFF, 513, 0);          // whole sum just above very complex
        send_split(8'h01, 1025, 0);
        send_random(200);

        // A stretch at full rate with no idling on either side. Early on, the
        // receiver holds off for a long while so that the block fills up and
        // stalls its input.
        apply_config(10, 1000, 4000, 16000, 60000);
        idle_enabled = 1'b0;
        hold_off_request = 1'b1;
        send_random(250);
        idle_enabled = 1'b1;

        // Widest bit depth with the thresholds at their extremes.
        apply_config(16, 0, 1, 65534, 65535);
        send_random(100);

        // A bit depth above the range behaves as the largest one.
        apply_config(31, 100, 200, 300, 400);
        send_random(100);

        // A bit depth below the range behaves as 8, and the thresholds are
        // deliberately out of order.
        apply_config(0, 5000, 100, 20000, 300);
        send_random(120);

        // All thresholds equal and at their maximum.
        apply_config(8, 65535, 65535, 65535, 65535);
        send_random(60);

        // Random ordered thresholds at random bit depths.
        repeat (4)
        begin
            rnd_ultra_flat    = $urandom_range(0, 4000);
            rnd_flat          = rnd_ultra_flat + $urandom_range(0, 8000);
            rnd_complex       = rnd_flat + $urandom_range(0, 20000);
            rnd_ultra_complex = rnd_complex + $urandom_range(0, 65535 - rnd_complex);
            apply_config($urandom_range(0, 31), rnd_ultra_flat, rnd_flat,
                         rnd_complex, rnd_ultra_complex);
            send_random(80);
        end

        wait_for_drain();
        if (level_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
